/* src/assert_macros.svh */
// Shared assertion macros, clocked on clk and held off during rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge.
`define LCS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Implication in the same cycle.
`define LCS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication in the next cycle.
`define LCS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* src/lcs_pkg.sv */
`timescale 1ns / 1ps
package lcs_pkg;
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int FRAC_BITS        = 12;
  localparam int OUT_WIDTH        = 16;
  localparam int NUM_LANES        = 4;
endpackage

/* src/levelset_curvature_stencil.sv */
`timescale 1ns / 1ps
// Beats pass abs, square, setup, residual and output registers in order.
// Throughput: one beat per cycle unless stalled; each of four normals steps
//   through a 13-stage residual pipeline (one quotient bit per stage).
// A stalled output beat freezes the whole pipeline; in_stall follows it.
// Reset (rst, synchronous) clears all stage valid bits; payload is not reset.
`include "assert_macros.svh"
module levelset_curvature_stencil #(
  parameter int SAMPLE_WIDTH = lcs_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0]       center,
  input  logic signed [SAMPLE_WIDTH-1:0]       off_0_p2,
  input  logic signed [SAMPLE_WIDTH-1:0]       off_0_m2,
  input  logic signed [SAMPLE_WIDTH-1:0]       off_p2_0,
  input  logic signed [SAMPLE_WIDTH-1:0]       off_m2_0,
  input  logic signed [SAMPLE_WIDTH-1:0]       off_p1_p1,
  input  logic signed [SAMPLE_WIDTH-1:0]       off_m1_p1,
  input  logic signed [SAMPLE_WIDTH-1:0]       off_p1_m1,
  input  logic signed [SAMPLE_WIDTH-1:0]       off_m1_m1,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [lcs_pkg::OUT_WIDTH-1:0] curvature,
  output logic                                 degenerate
);
  import lcs_pkg::*;

  localparam int SW  = SAMPLE_WIDTH;
  localparam int DW  = SW + 1;
  localparam int QW  = 2 * SW;
  localparam int SQW = 2 * SW + 1;
  localparam int RW  = 2 * SW + 30;
  localparam int NB  = FRAC_BITS + 1;
  localparam int NV  = NB + 4;

  logic ce;
  logic [NV-1:0] vld;

  assign ce       = !(out_valid && out_stall);
  assign in_stall = !ce;

  // stage 1: difference vectors
  logic signed [DW-1:0] num_d [NUM_LANES];
  logic signed [DW-1:0] oth_d [NUM_LANES];
  logic signed [DW-1:0] c_x, p02, m02, p20, m20, p11, m1p1, p1m1, m11;
  logic degen_d;

  always_comb begin
    c_x  = DW'(center);
    p02  = DW'(off_0_p2);
    m02  = DW'(off_0_m2);
    p20  = DW'(off_p2_0);
    m20  = DW'(off_m2_0);
    p11  = DW'(off_p1_p1);
    m1p1 = DW'(off_m1_p1);
    p1m1 = DW'(off_p1_m1);
    m11  = DW'(off_m1_m1);
    num_d[0] = p02 - c_x;   oth_d[0] = p11 - m1p1;
    num_d[1] = c_x - m02;   oth_d[1] = p1m1 - m11;
    num_d[2] = p20 - c_x;   oth_d[2] = p11 - p1m1;
    num_d[3] = c_x - m20;   oth_d[3] = m1p1 - m11;
    degen_d = 1'b0;
    for (int l = 0; l < NUM_LANES; l++) begin
      if (num_d[l] == '0 && oth_d[l] == '0) begin
        degen_d = 1'b1;
      end
    end
  end

  logic [SW-1:0] a1 [NUM_LANES];
  logic [SW-1:0] b1 [NUM_LANES];
  logic [QW-1:0] asq2 [NUM_LANES];
  logic [QW-1:0] bsq2 [NUM_LANES];
  logic [NUM_LANES-1:0] neg1, nz1, neg2, nz2;
  logic degen1, degen2;

  logic signed [RW-1:0] rr [NUM_LANES][NB+1];
  logic signed [RW-1:0] pp [NUM_LANES][NB+1];
  logic [SQW-1:0]       ss [NUM_LANES][NB+1];
  logic [NB-1:0]        nn [NUM_LANES][NB+1];
  logic [NUM_LANES-1:0] negs [NB+1];
  logic [NUM_LANES-1:0] nzs  [NB+1];
  logic                 degs [NB+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[NV-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      degen1 <= degen_d;
      for (int l = 0; l < NUM_LANES; l++) begin
        a1[l]   <= num_d[l][DW-1] ? SW'(-num_d[l]) : SW'(num_d[l]);
        b1[l]   <= oth_d[l][DW-1] ? SW'(-oth_d[l]) : SW'(oth_d[l]);
        neg1[l] <= num_d[l][DW-1];
        nz1[l]  <= (num_d[l] != '0);
      end
      for (int l = 0; l < NUM_LANES; l++) begin
        asq2[l] <= QW'(a1[l]) * QW'(a1[l]);
        bsq2[l] <= QW'(b1[l]) * QW'(b1[l]);
      end
      neg2   <= neg1;
      nz2    <= nz1;
      degen2 <= degen1;
      for (int l = 0; l < NUM_LANES; l++) begin
        ss[l][0] <= SQW'(asq2[l]) + SQW'(bsq2[l]);
        rr[l][0] <= (RW'(asq2[l]) <<< 26) - RW'(asq2[l]) - RW'(bsq2[l]);
        pp[l][0] <= -(RW'(asq2[l]) + RW'(bsq2[l]));
        nn[l][0] <= '0;
      end
      negs[0] <= neg2;
      nzs[0]  <= nz2;
      degs[0] <= degen2;
    end
  end

  // residual steps: test x' = x + 2*bit against A - x^2*S
  for (genvar k = 0; k < NB; k++) begin : g_step
    localparam int LG = NB - 1 - k;
    for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
      logic signed [RW-1:0] d;
      logic take;
      assign d    = (pp[l][k] <<< (LG + 2)) + (RW'(ss[l][k]) <<< (2 * LG + 2));
      assign take = (d <= rr[l][k]);
      always_ff @(posedge clk) begin
        if (ce) begin
          ss[l][k+1] <= ss[l][k];
          if (take) begin
            rr[l][k+1] <= rr[l][k] - d;
            pp[l][k+1] <= pp[l][k] + (RW'(ss[l][k]) <<< (LG + 1));
            nn[l][k+1] <= nn[l][k] | (NB'(1) << LG);
          end else begin
            rr[l][k+1] <= rr[l][k];
            pp[l][k+1] <= pp[l][k];
            nn[l][k+1] <= nn[l][k];
          end
        end
      end
    end
    always_ff @(posedge clk) begin
      if (ce) begin
        negs[k+1] <= negs[k];
        nzs[k+1]  <= nzs[k];
        degs[k+1] <= degs[k];
      end
    end
  end

  logic signed [OUT_WIDTH-1:0] comp [NUM_LANES];
  logic signed [OUT_WIDTH-1:0] sum_next;

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      if (!nzs[NB][l]) begin
        comp[l] = '0;
      end else if (negs[NB][l]) begin
        comp[l] = -OUT_WIDTH'(nn[l][NB]);
      end else begin
        comp[l] = OUT_WIDTH'(nn[l][NB]);
      end
    end
    sum_next = comp[0] - comp[1] + comp[2] - comp[3];
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      curvature  <= sum_next;
      degenerate <= degs[NB];
    end
  end

  assign out_valid = vld[NV-1];

  `LCS_ASSERT(a_stall_map, in_stall == (out_valid && out_stall))
  `LCS_ASSERT_IMP(a_range, out_valid, curvature >= -16384 && curvature <= 16384)
  `LCS_ASSERT_NXT(a_freeze, out_valid && out_stall && !rst, vld == $past(vld))

endmodule
